// File: design/mbi_pkg.sv
// shared types, constants and helpers of the mandelbrot escape iterator
// used by mbi_front, mbi_queue, mbi_back and mandelbrot_escape_iterator_core
// no dependencies
package mbi_pkg;

    // fixed field widths
    localparam int DIM_W   = 12;
    localparam int COUNT_W = 11;
    localparam int WORD_W  = 32;
    localparam int STEP_W  = 31;
    localparam int SHIFT_W = 3;
    localparam int CFG_IDX_W = 3;

    // iteration limit and image size bound
    localparam int ITER_LIMIT = 1024;
    localparam int MAX_DIM    = 4096;

    // palette
    localparam int PAL_MOD = 255;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_IM      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IM     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_SHIFT = 3'd4;

    // configuration reset values
    localparam logic signed [WORD_W-1:0] ORIGIN_RE_RST = -32'sd738197504;
    localparam logic signed [WORD_W-1:0] TOP_IM_RST    = 32'sd402653184;
    localparam logic [STEP_W-1:0]        STEP_RE_RST   = 31'd1048576;
    localparam logic [STEP_W-1:0]        STEP_IM_RST   = 31'd1048576;
    localparam logic [SHIFT_W-1:0]       SHIFT_RST     = 3'd0;

    // input item
    typedef struct packed {
        logic [DIM_W-1:0] column;
        logic [DIM_W-1:0] row;
    } item_t;

    // result item
    typedef struct packed {
        logic [DIM_W-1:0]   out_column;
        logic [DIM_W-1:0]   out_row;
        logic [COUNT_W-1:0] iteration_count;
        logic               inside_set;
        logic [7:0]         color_index;
    } result_t;

    // configuration as seen by front and back
    typedef struct packed {
        logic signed [WORD_W-1:0] origin_re;
        logic signed [WORD_W-1:0] top_im;
        logic [STEP_W-1:0]        step_re;
        logic [STEP_W-1:0]        step_im;
        logic [SHIFT_W-1:0]       color_shift;
    } cfg_t;

    // queued job: pixel plus its point c
    typedef struct packed {
        item_t                    pix;
        logic signed [WORD_W-1:0] cr;
        logic signed [WORD_W-1:0] ci;
    } job_t;

    // saturate a 64 bit signed value to the 32 bit signed range
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < lo)
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return v[WORD_W-1:0];
        end
    endfunction

endpackage

// File: design/mbi_front.sv
// front part: accepts a pixel, forms the point c and pushes the job to the queue
// depends on mbi_pkg
module mbi_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mbi_pkg::item_t item,
    input  mbi_pkg::cfg_t  cfg,
    input  logic          q_full,
    output logic          q_push,
    output mbi_pkg::job_t q_data
);

    localparam int PROD_W = mbi_pkg::DIM_W + mbi_pkg::STEP_W;

    logic                      a_valid_reg;
    logic                      a_valid_next;
    mbi_pkg::item_t            pix_reg;
    logic [PROD_W-1:0]         off_re_reg;
    logic [PROD_W-1:0]         off_im_reg;
    logic [mbi_pkg::DIM_W-1:0] col_clamp;
    logic [mbi_pkg::DIM_W-1:0] row_clamp;
    logic                      accept;
    logic signed [63:0]        cr_full;
    logic signed [63:0]        ci_full;

    assign accept = start && !a_valid_reg;
    assign busy   = a_valid_reg;
    assign q_push = a_valid_reg && !q_full;

    // coordinates beyond the image bound are clamped for forming c
    always_comb
    begin
        col_clamp = item.column;
        row_clamp = item.row;
        if (({1'b0, item.column}) > (mbi_pkg::DIM_W+1)'(mbi_pkg::MAX_DIM - 1))
        begin
            col_clamp = mbi_pkg::DIM_W'(mbi_pkg::MAX_DIM - 1);
        end
        if (({1'b0, item.row}) > (mbi_pkg::DIM_W+1)'(mbi_pkg::MAX_DIM - 1))
        begin
            row_clamp = mbi_pkg::DIM_W'(mbi_pkg::MAX_DIM - 1);
        end
    end

    // stage valid
    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    // pixel offsets, one multiplier per axis
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg    <= item;
            off_re_reg <= PROD_W'(col_clamp) * PROD_W'(cfg.step_re);
            off_im_reg <= PROD_W'(row_clamp) * PROD_W'(cfg.step_im);
        end
    end

    // c from origin and offsets, saturated
    always_comb
    begin
        cr_full = {{(64-mbi_pkg::WORD_W){cfg.origin_re[mbi_pkg::WORD_W-1]}}, cfg.origin_re}
                + $signed({{(64-PROD_W){1'b0}}, off_re_reg});
        ci_full = {{(64-mbi_pkg::WORD_W){cfg.top_im[mbi_pkg::WORD_W-1]}}, cfg.top_im}
                - $signed({{(64-PROD_W){1'b0}}, off_im_reg});
        q_data.pix = pix_reg;
        q_data.cr  = mbi_pkg::sat32(cr_full);
        q_data.ci  = mbi_pkg::sat32(ci_full);
    end

endmodule

// File: design/mbi_queue.sv
// short job queue between front and back
// depends on mbi_pkg
module mbi_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mbi_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output mbi_pkg::job_t pop_data,
    output logic          empty
);

    mbi_pkg::job_t                 entry_reg [mbi_pkg::QDEPTH];
    logic [mbi_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mbi_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [mbi_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mbi_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [mbi_pkg::QCNT_W-1:0]    cnt_reg;
    logic [mbi_pkg::QCNT_W-1:0]    cnt_next;
    logic                          do_push;
    logic                          do_pop;

    assign full     = (cnt_reg == mbi_pkg::QCNT_W'(mbi_pkg::QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/mbi_back.sv
// back part: iterates z = z*z + c, one iteration per cycle, and forms the result
// depends on mbi_pkg
module mbi_back #(
    parameter int FRAC_BITS = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mbi_pkg::SHIFT_W-1:0]   color_shift,
    input  logic                          q_empty,
    input  mbi_pkg::job_t                 q_data,
    output logic                          q_pop,
    output logic                          done,
    output mbi_pkg::result_t              result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam int   CSH_W   = mbi_pkg::COUNT_W + (1 << mbi_pkg::SHIFT_W) - 1;
    localparam int   HI_W    = CSH_W - 8;
    localparam int   S1_W    = HI_W + 1;
    localparam logic signed [63:0] LIMIT4 = 64'sd4 <<< FRAC_BITS;

    logic                              state_reg;
    logic                              state_next;
    mbi_pkg::item_t                    pix_reg;
    logic signed [mbi_pkg::WORD_W-1:0] cr_reg;
    logic signed [mbi_pkg::WORD_W-1:0] ci_reg;
    logic signed [mbi_pkg::WORD_W-1:0] zr_reg;
    logic signed [mbi_pkg::WORD_W-1:0] zi_reg;
    logic [mbi_pkg::COUNT_W-1:0]       count_reg;
    logic                              done_reg;
    logic                              done_next;
    mbi_pkg::result_t                  result_reg;
    mbi_pkg::result_t                  result_next;

    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic signed [63:0] p_ri;
    logic signed [63:0] rr;
    logic signed [63:0] ii;
    logic signed [63:0] ri2;
    logic signed [63:0] mag;
    logic signed [63:0] nr_full;
    logic signed [63:0] ni_full;
    logic               escape;
    logic               at_limit;
    logic               stop;

    logic [CSH_W-1:0]   shifted;
    logic [S1_W-1:0]    sum1;
    logic [8:0]         sum2;
    logic [7:0]         color;

    assign q_pop  = (state_reg == ST_IDLE) && !q_empty;
    assign done   = done_reg;
    assign result = result_reg;

    // squares and cross product of z, then the new z and the escape test
    always_comb
    begin
        p_rr     = zr_reg * zr_reg;
        p_ii     = zi_reg * zi_reg;
        p_ri     = zr_reg * zi_reg;
        rr       = p_rr >>> FRAC_BITS;
        ii       = p_ii >>> FRAC_BITS;
        ri2      = p_ri >>> (FRAC_BITS - 1);
        mag      = rr + ii;
        nr_full  = rr - ii + {{(64-mbi_pkg::WORD_W){cr_reg[mbi_pkg::WORD_W-1]}}, cr_reg};
        ni_full  = ri2 + {{(64-mbi_pkg::WORD_W){ci_reg[mbi_pkg::WORD_W-1]}}, ci_reg};
        escape   = (mag >= LIMIT4);
        at_limit = (count_reg >= mbi_pkg::COUNT_W'(mbi_pkg::ITER_LIMIT));
        stop     = escape || at_limit;
    end

    // palette index: count shifted, reduced mod 255 by folding bytes
    always_comb
    begin
        shifted = CSH_W'(count_reg) << color_shift;
        sum1    = S1_W'(shifted[CSH_W-1:8]) + S1_W'(shifted[7:0]);
        sum2    = 9'(sum1[S1_W-1:8]) + 9'(sum1[7:0]);
        if (sum2 >= 9'(mbi_pkg::PAL_MOD))
        begin
            sum2 = sum2 - 9'(mbi_pkg::PAL_MOD);
        end
        if ((count_reg == '0) || at_limit)
        begin
            color = 8'd0;
        end
        else
        begin
            color = sum2[7:0] + 8'd1;
        end
    end

    // sequencing and result forming
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (stop)
                begin
                    state_next                  = ST_IDLE;
                    done_next                   = 1'b1;
                    result_next.out_column      = pix_reg.column;
                    result_next.out_row         = pix_reg.row;
                    result_next.iteration_count = count_reg;
                    result_next.inside_set      = at_limit;
                    result_next.color_index     = color;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // job load and iteration update
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (q_pop)
        begin
            pix_reg   <= q_data.pix;
            cr_reg    <= q_data.cr;
            ci_reg    <= q_data.ci;
            zr_reg    <= q_data.cr;
            zi_reg    <= q_data.ci;
            count_reg <= '0;
        end
        else if ((state_reg == ST_RUN) && !stop)
        begin
            zr_reg    <= mbi_pkg::sat32(nr_full);
            zi_reg    <= mbi_pkg::sat32(ni_full);
            count_reg <= count_reg + 1'b1;
        end
    end

endmodule

// File: design/mandelbrot_escape_iterator_core.sv
// top level of the mandelbrot escape iterator: configuration registers,
// front, job queue and back; depends on mbi_pkg, mbi_front, mbi_queue, mbi_back
//
// Give a pixel by raising start with column and row on item while busy is low.
// The front forms the point c from registered offsets and queues it; the back
// runs the escape loop at one iteration per cycle, so a pixel holds the back
// until it escapes or reaches the iteration limit, and that loop sets the
// sustained rate. Each result shows on result for exactly one cycle with done
// high and must be taken then: the receiver cannot stall the block. Registers
// are written through cfg_we, cfg_index and cfg_data at any edge; write them
// only while no pixel is in flight.
module mandelbrot_escape_iterator_core #(
    parameter int FRAC_BITS = 28
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  mbi_pkg::item_t                  item,
    output logic                            done,
    output mbi_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [mbi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbi_pkg::WORD_W-1:0]      cfg_data
);

    mbi_pkg::cfg_t cfg_reg;
    mbi_pkg::job_t push_data;
    mbi_pkg::job_t pop_data;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_re   <= mbi_pkg::ORIGIN_RE_RST;
            cfg_reg.top_im      <= mbi_pkg::TOP_IM_RST;
            cfg_reg.step_re     <= mbi_pkg::STEP_RE_RST;
            cfg_reg.step_im     <= mbi_pkg::STEP_IM_RST;
            cfg_reg.color_shift <= mbi_pkg::SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbi_pkg::REG_ORIGIN_RE:   cfg_reg.origin_re   <= cfg_data;
                mbi_pkg::REG_TOP_IM:      cfg_reg.top_im      <= cfg_data;
                mbi_pkg::REG_STEP_RE:     cfg_reg.step_re     <= cfg_data[mbi_pkg::STEP_W-1:0];
                mbi_pkg::REG_STEP_IM:     cfg_reg.step_im     <= cfg_data[mbi_pkg::STEP_W-1:0];
                mbi_pkg::REG_COLOR_SHIFT: cfg_reg.color_shift <= cfg_data[mbi_pkg::SHIFT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // front: accept and form c
    mbi_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (push_data)
    );

    // job queue
    mbi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // back: escape loop and result
    mbi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .color_shift (cfg_reg.color_shift),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .q_pop       (q_pop),
        .done        (done),
        .result      (result)
    );

endmodule

// File: sim/mandelbrot_escape_iterator_core_tb.sv
// self-checking testbench for mandelbrot_escape_iterator_core: directed plan, then random view windows
// depends on mbi_pkg and the core; results are checked against an escape-time predictor below
module mandelbrot_escape_iterator_core_tb;

    localparam int FRAC_BITS = 28;

    // register index that decodes to nothing
    localparam logic [mbi_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // one row of the directed plan: a register write or a pixel
    typedef struct packed {
        logic                          reg_write;
        logic [mbi_pkg::CFG_IDX_W-1:0] idx;
        logic [mbi_pkg::WORD_W-1:0]    data;
        mbi_pkg::item_t                px;
        logic                          known;
        logic [mbi_pkg::COUNT_W-1:0]   count;
        logic                          in_set;
    } plan_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    mbi_pkg::item_t                pixel_in = '0;
    logic                          done;
    mbi_pkg::result_t              pixel_out;
    logic                          cfg_we = 1'b0;
    logic [mbi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mbi_pkg::WORD_W-1:0]    cfg_data = '0;

    // register copy used by the predictor
    int                            mirror_origin_re = mbi_pkg::ORIGIN_RE_RST;
    int                            mirror_top_im = mbi_pkg::TOP_IM_RST;
    logic [mbi_pkg::STEP_W-1:0]    mirror_step_re = mbi_pkg::STEP_RE_RST;
    logic [mbi_pkg::STEP_W-1:0]    mirror_step_im = mbi_pkg::STEP_IM_RST;
    logic [mbi_pkg::SHIFT_W-1:0]   mirror_color_shift = mbi_pkg::SHIFT_RST;

    mbi_pkg::result_t              awaited_pixels[$];
    plan_row_t                     plan[$];
    int                            burst_left = 0;
    int                            pixels_sent = 0;
    int                            pixels_seen = 0;
    int                            inside_seen = 0;
    int                            reg_writes = 0;
    int                            mismatches = 0;

    mandelbrot_escape_iterator_core #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(pixel_in),
        .done(done),
        .result(pixel_out),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // clip to the signed 32 bit range
    function automatic int clip_word(longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return int'(v);
    endfunction

    // escape-time count, inside flag and palette index of one pixel
    function automatic mbi_pkg::result_t escape_pixel(mbi_pkg::item_t px);
        longint col_l;
        longint row_l;
        longint stp_re;
        longint stp_im;
        longint base_re;
        longint base_im;
        longint a;
        longint b;
        longint mag;
        longint four;
        int cr;
        int ci;
        int zr;
        int zi;
        int nr;
        int ni;
        int unsigned n;
        int unsigned color;
        mbi_pkg::result_t r;
        col_l = longint'(px.column);
        row_l = longint'(px.row);
        if (col_l > mbi_pkg::MAX_DIM - 1)
        begin
            col_l = mbi_pkg::MAX_DIM - 1;
        end
        if (row_l > mbi_pkg::MAX_DIM - 1)
        begin
            row_l = mbi_pkg::MAX_DIM - 1;
        end
        stp_re = longint'(mirror_step_re);
        stp_im = longint'(mirror_step_im);
        base_re = mirror_origin_re;
        base_im = mirror_top_im;
        cr = clip_word(base_re + col_l * stp_re);
        ci = clip_word(base_im - row_l * stp_im);
        four = 64'sd4 <<< FRAC_BITS;
        zr = 0;
        zi = 0;
        n = 0;
        forever
        begin
            a = zr;
            b = zi;
            nr = clip_word(((a * a) >>> FRAC_BITS) - ((b * b) >>> FRAC_BITS) + longint'(cr));
            ni = clip_word(((a * b) >>> (FRAC_BITS - 1)) + longint'(ci));
            a = nr;
            b = ni;
            mag = ((a * a) >>> FRAC_BITS) + ((b * b) >>> FRAC_BITS);
            if (mag >= four)
            begin
                break;
            end
            if (n >= mbi_pkg::ITER_LIMIT)
            begin
                break;
            end
            zr = nr;
            zi = ni;
            n++;
        end
        if (n == 0 || n >= mbi_pkg::ITER_LIMIT)
        begin
            color = 0;
        end
        else
        begin
            color = ((n << mirror_color_shift) % mbi_pkg::PAL_MOD) + 1;
        end
        r.out_column = px.column;
        r.out_row = px.row;
        r.iteration_count = n[mbi_pkg::COUNT_W-1:0];
        r.inside_set = (n >= mbi_pkg::ITER_LIMIT);
        r.color_index = color[7:0];
        return r;
    endfunction

    // plan row builders
    function automatic plan_row_t pixel_row(int col, int rw);
        plan_row_t r;
        r = '0;
        r.px.column = mbi_pkg::DIM_W'(col);
        r.px.row = mbi_pkg::DIM_W'(rw);
        return r;
    endfunction

    function automatic plan_row_t known_row(int col, int rw, int cnt, bit ins);
        plan_row_t r;
        r = pixel_row(col, rw);
        r.known = 1'b1;
        r.count = mbi_pkg::COUNT_W'(cnt);
        r.in_set = ins;
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [mbi_pkg::CFG_IDX_W-1:0] idx,
                                          logic [mbi_pkg::WORD_W-1:0] data);
        plan_row_t r;
        r = '0;
        r.reg_write = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic void flag_mismatch(string what, mbi_pkg::result_t want,
                                          logic [31:0] exp_v, logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s mismatch at pixel (%0d,%0d): expected %0d, got %0d",
                     what, want.out_column, want.out_row, exp_v, got_v);
        end
    endfunction

    // register write while the block is idle
    task automatic write_reg(logic [mbi_pkg::CFG_IDX_W-1:0] idx,
                             logic [mbi_pkg::WORD_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            mbi_pkg::REG_ORIGIN_RE:   mirror_origin_re = data;
            mbi_pkg::REG_TOP_IM:      mirror_top_im = data;
            mbi_pkg::REG_STEP_RE:     mirror_step_re = data[mbi_pkg::STEP_W-1:0];
            mbi_pkg::REG_STEP_IM:     mirror_step_im = data[mbi_pkg::STEP_W-1:0];
            mbi_pkg::REG_COLOR_SHIFT: mirror_color_shift = data[mbi_pkg::SHIFT_W-1:0];
            default:                  ;
        endcase
        reg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // sender bursts with random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // hand one pixel over and remember its result
    task automatic feed_pixel(mbi_pkg::item_t px, mbi_pkg::result_t want);
        start <= 1'b1;
        pixel_in <= px;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        awaited_pixels.push_back(want);
        pixels_sent++;
    endtask

    // wait until every pixel in flight has come back
    task automatic settle();
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (awaited_pixels.size() != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    // result checking
    always @(posedge clk)
    begin : check_results
        mbi_pkg::result_t want;
        if (rst_n && done)
        begin
            pixels_seen++;
            if (pixel_out.inside_set === 1'b1)
            begin
                inside_seen++;
            end
            if (awaited_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result for pixel (%0d,%0d) with nothing pending",
                             pixel_out.out_column, pixel_out.out_row);
                end
            end
            else
            begin
                want = awaited_pixels.pop_front();
                if (pixel_out.out_column !== want.out_column)
                begin
                    flag_mismatch("out_column", want, 32'(want.out_column),
                                  32'(pixel_out.out_column));
                end
                if (pixel_out.out_row !== want.out_row)
                begin
                    flag_mismatch("out_row", want, 32'(want.out_row), 32'(pixel_out.out_row));
                end
                if (pixel_out.iteration_count !== want.iteration_count)
                begin
                    flag_mismatch("iteration_count", want, 32'(want.iteration_count),
                                  32'(pixel_out.iteration_count));
                end
                if (pixel_out.inside_set !== want.inside_set)
                begin
                    flag_mismatch("inside_set", want, 32'(want.inside_set),
                                  32'(pixel_out.inside_set));
                end
                if (pixel_out.color_index !== want.color_index)
                begin
                    flag_mismatch("color_index", want, 32'(want.color_index),
                                  32'(pixel_out.color_index));
                end
            end
        end
    end

    // stimulus
    initial
    begin : run
        plan_row_t r;
        mbi_pkg::item_t px;
        mbi_pkg::result_t want;
        int i;
        int phase;
        int k;
        int win;
        int span;

        // reset view: c = -2.75 + 1.5i at pixel 0, 1/256 per pixel
        plan.push_back(known_row(0, 0, 0, 1'b0));
        plan.push_back(known_row(4095, 4095, 0, 1'b0));
        plan.push_back(known_row(704, 384, mbi_pkg::ITER_LIMIT, 1'b1));   // c = 0 never escapes
        plan.push_back(known_row(192, 384, 0, 1'b0));            // c = -2 lands exactly on |z|^2 = 4
        plan.push_back(known_row(0, 4095, 0, 1'b0));
        plan.push_back(known_row(4095, 0, 0, 1'b0));
        plan.push_back(pixel_row(512, 384));
        plan.push_back(pixel_row(640, 256));
        plan.push_back(pixel_row(700, 300));
        plan.push_back(pixel_row(760, 200));
        plan.push_back(pixel_row(600, 500));
        // widest palette shift, counts wrap the palette
        plan.push_back(reg_row(mbi_pkg::REG_COLOR_SHIFT, 32'd7));
        plan.push_back(pixel_row(640, 256));
        plan.push_back(pixel_row(700, 300));
        plan.push_back(pixel_row(760, 200));
        plan.push_back(pixel_row(650, 200));
        plan.push_back(known_row(704, 384, mbi_pkg::ITER_LIMIT, 1'b1));
        // c saturates at both ends
        plan.push_back(reg_row(mbi_pkg::REG_ORIGIN_RE, 32'h7FFF_FFFF));
        plan.push_back(reg_row(mbi_pkg::REG_TOP_IM, 32'h8000_0000));
        plan.push_back(reg_row(mbi_pkg::REG_STEP_RE, 32'h7FFF_FFFF));
        plan.push_back(reg_row(mbi_pkg::REG_STEP_IM, 32'h7FFF_FFFF));
        plan.push_back(known_row(4095, 4095, 0, 1'b0));
        plan.push_back(known_row(0, 0, 0, 1'b0));
        // write to an index that decodes to nothing
        plan.push_back(reg_row(REG_SPARE, 32'hFFFF_FFFF));
        plan.push_back(known_row(4095, 0, 0, 1'b0));
        // zero steps: every pixel sits on c = 0, then on c = -8 once origin_re is set to its minimum
        plan.push_back(reg_row(mbi_pkg::REG_ORIGIN_RE, 32'd0));
        plan.push_back(reg_row(mbi_pkg::REG_TOP_IM, 32'd0));
        plan.push_back(reg_row(mbi_pkg::REG_STEP_RE, 32'd0));
        plan.push_back(reg_row(mbi_pkg::REG_STEP_IM, 32'd0));
        plan.push_back(known_row(4095, 0, mbi_pkg::ITER_LIMIT, 1'b1));
        plan.push_back(reg_row(mbi_pkg::REG_ORIGIN_RE, 32'h8000_0000));
        plan.push_back(known_row(123, 456, 0, 1'b0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        for (i = 0; i < plan.size(); i++)
        begin
            r = plan[i];
            if (r.reg_write)
            begin
                settle();
                write_reg(r.idx, r.data);
            end
            else
            begin
                if (r.known)
                begin
                    want.out_column = r.px.column;
                    want.out_row = r.px.row;
                    want.iteration_count = r.count;
                    want.inside_set = r.in_set;
                    want.color_index = 8'd0;
                end
                else
                begin
                    want = escape_pixel(r.px);
                end
                pace_sender();
                feed_pixel(r.px, want);
            end
        end

        // random phases: two extreme settings, then windows over the set
        for (phase = 0; phase < 10; phase++)
        begin
            settle();
            win = mbi_pkg::MAX_DIM;
            if (phase == 0)
            begin
                write_reg(mbi_pkg::REG_ORIGIN_RE, 32'h7FFF_FFFF);
                write_reg(mbi_pkg::REG_TOP_IM, 32'h7FFF_FFFF);
                write_reg(mbi_pkg::REG_STEP_RE, 32'hFFFF_FFFF);
                write_reg(mbi_pkg::REG_STEP_IM, 32'hFFFF_FFFF);
                write_reg(mbi_pkg::REG_COLOR_SHIFT, 32'hFFFF_FFFF);
            end
            else if (phase == 1)
            begin
                write_reg(mbi_pkg::REG_ORIGIN_RE, 32'h8000_0000);
                write_reg(mbi_pkg::REG_TOP_IM, 32'h8000_0000);
                write_reg(mbi_pkg::REG_STEP_RE, 32'd0);
                write_reg(mbi_pkg::REG_STEP_IM, 32'd0);
                write_reg(mbi_pkg::REG_COLOR_SHIFT, 32'd0);
            end
            else
            begin
                // a view 1.5 to 3 units a side from near -2.25 + 1.25i, win pixels a side
                win = 1 << $urandom_range(4, 8);
                span = (3 << FRAC_BITS) / win;
                write_reg(mbi_pkg::REG_ORIGIN_RE,
                          -603979776 + $urandom_range(0, 1 << 27) - (1 << 26));
                write_reg(mbi_pkg::REG_TOP_IM,
                          335544320 + $urandom_range(0, 1 << 27) - (1 << 26));
                write_reg(mbi_pkg::REG_STEP_RE, $urandom_range(span / 2, span));
                write_reg(mbi_pkg::REG_STEP_IM, $urandom_range(span / 2, span));
                write_reg(mbi_pkg::REG_COLOR_SHIFT, $urandom_range(0, 7));
            end
            for (k = 0; k < 50; k++)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    px.column = mbi_pkg::DIM_W'($urandom_range(0, win - 1));
                    px.row = mbi_pkg::DIM_W'($urandom_range(0, win - 1));
                end
                else
                begin
                    px.column = mbi_pkg::DIM_W'($urandom_range(0, mbi_pkg::MAX_DIM - 1));
                    px.row = mbi_pkg::DIM_W'($urandom_range(0, mbi_pkg::MAX_DIM - 1));
                end
                pace_sender();
                feed_pixel(px, escape_pixel(px));
            end
        end

        settle();
        // room for a stray result after the last one
        repeat (mbi_pkg::ITER_LIMIT + 64) @(posedge clk);

        $display("%0d pixels sent, %0d results checked, %0d of them inside the set",
                 pixels_sent, pixels_seen, inside_seen);
        $display("%0d register writes: directed extremes and 8 random view windows",
                 reg_writes);
        if (mismatches == 0)
        begin
            $display("mandelbrot_escape_iterator_core_tb passed");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("mandelbrot_escape_iterator_core_tb failed");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("timeout with %0d results still pending", awaited_pixels.size());
        $display("mandelbrot_escape_iterator_core_tb failed");
        $finish;
    end

endmodule
